@@ rtl/sft_pkg.sv @@
package sft_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_FLAG         = 3'd0;
  localparam logic [2:0] REG_ESCAPE       = 3'd1;
  localparam logic [2:0] REG_FLAG_SUBST   = 3'd2;
  localparam logic [2:0] REG_ESCAPE_SUBST = 3'd3;
  localparam logic [2:0] REG_ADDRESS      = 3'd4;
  localparam logic [2:0] REG_CTRL_SEQ0    = 3'd5;
  localparam logic [2:0] REG_CTRL_SEQ1    = 3'd6;
  localparam logic [2:0] REG_TRY_LIMIT    = 3'd7;

  // Reset values of the configuration registers
  localparam logic [7:0] FLAG_RST         = 8'd126;
  localparam logic [7:0] ESCAPE_RST       = 8'd125;
  localparam logic [7:0] FLAG_SUBST_RST   = 8'd94;
  localparam logic [7:0] ESCAPE_SUBST_RST = 8'd93;
  localparam logic [7:0] ADDRESS_RST      = 8'd3;
  localparam logic [7:0] CTRL_SEQ0_RST    = 8'd0;
  localparam logic [7:0] CTRL_SEQ1_RST    = 8'd64;
  localparam logic [3:0] TRY_LIMIT_RST    = 4'd3;

  // Input modes
  localparam logic MODE_PAYLOAD = 1'b0;
  localparam logic MODE_REPLY   = 1'b1;

  // Reply kinds
  localparam logic [1:0] REPLY_READY = 2'd0;

  // Result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  // Acknowledgement status codes
  localparam logic [1:0] ACK_ACCEPTED = 2'd0;
  localparam logic [1:0] ACK_RESEND   = 2'd1;
  localparam logic [1:0] ACK_GAVE_UP  = 2'd2;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] flag_subst;
    logic [7:0] escape_subst;
    logic [7:0] address;
    logic [7:0] ctrl_seq0;
    logic [7:0] ctrl_seq1;
    logic [3:0] try_limit;
  } sft_cfg_t;

  // One classified item handed from the front to the back
  typedef struct packed {
    logic       is_ack;
    logic       first;
    logic       last;
    logic [7:0] ctrl;
    logic [7:0] pbyte;
    logic [7:0] parity;
    logic [1:0] status;
  } sft_desc_t;

endpackage

@@ rtl/sft_if.sv @@
interface sft_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic       last_byte;
  logic [1:0] reply_kind;
  logic       reply_seq;

  modport source (output valid, mode, payload_byte, first_byte, last_byte, reply_kind,
                  reply_seq, input ready);
  modport sink   (input valid, mode, payload_byte, first_byte, last_byte, reply_kind,
                  reply_seq, output ready);
endinterface

interface sft_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_kind;
  logic [1:0] ack_status;

  modport source (output valid, out_byte, out_last, out_kind, ack_status, input ready);
  modport sink   (input valid, out_byte, out_last, out_kind, ack_status, output ready);
endinterface

@@ rtl/sft_front.sv @@
module sft_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sft_pkg::sft_cfg_t   cfg_i,
  sft_in_if.sink              in_i,
  input  logic                full_i,
  output logic                push_o,
  output sft_pkg::sft_desc_t  desc_o
);
  import sft_pkg::*;

  logic       seq_q, seq_d;
  logic [7:0] parity_q, parity_d;
  logic [3:0] tries_q, tries_d;
  logic [3:0] tries_dec;
  logic       accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;
  assign tries_dec  = tries_q - 4'd1;

  // Classify the transaction and update frame and link state
  always_comb begin
    seq_d    = seq_q;
    parity_d = parity_q;
    tries_d  = tries_q;
    desc_o   = '0;
    desc_o.pbyte = in_i.payload_byte;
    desc_o.first = in_i.first_byte;
    desc_o.last  = in_i.last_byte;
    desc_o.ctrl  = seq_q ? cfg_i.ctrl_seq1 : cfg_i.ctrl_seq0;
    if (in_i.mode == MODE_PAYLOAD) begin
      if (in_i.first_byte) begin
        parity_d = in_i.payload_byte;
        tries_d  = cfg_i.try_limit;
      end else begin
        parity_d = parity_q ^ in_i.payload_byte;
      end
    end else begin
      desc_o.is_ack = 1'b1;
      if (tries_q == 4'd0) begin
        desc_o.status = ACK_GAVE_UP;
      end else if (in_i.reply_kind == REPLY_READY && in_i.reply_seq != seq_q) begin
        desc_o.status = ACK_ACCEPTED;
        seq_d         = !seq_q;
        tries_d       = cfg_i.try_limit;
      end else begin
        tries_d       = tries_dec;
        desc_o.status = (tries_dec == 4'd0) ? ACK_GAVE_UP : ACK_RESEND;
      end
    end
    desc_o.parity = parity_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= 1'b0;
      parity_q <= 8'd0;
      tries_q  <= TRY_LIMIT_RST;
    end else if (accept) begin
      seq_q    <= seq_d;
      parity_q <= parity_d;
      tries_q  <= tries_d;
    end
  end

endmodule

@@ rtl/sft_queue.sv @@
module sft_queue #(
  parameter int Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sft_pkg::sft_desc_t  desc_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output sft_pkg::sft_desc_t  head_o
);
  import sft_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sft_desc_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

endmodule

@@ rtl/sft_back.sv @@
module sft_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sft_pkg::sft_cfg_t   cfg_i,
  input  logic                head_valid_i,
  input  sft_pkg::sft_desc_t  head_i,
  output logic                pop_o,
  sft_out_if.source           out_o
);
  import sft_pkg::*;

  localparam logic [3:0] PH_FLAG_OPEN  = 4'd0;
  localparam logic [3:0] PH_ADDRESS    = 4'd1;
  localparam logic [3:0] PH_CTRL       = 4'd2;
  localparam logic [3:0] PH_HDR_PARITY = 4'd3;
  localparam logic [3:0] PH_PAYLOAD    = 4'd4;
  localparam logic [3:0] PH_PAYLOAD_SUB = 4'd5;
  localparam logic [3:0] PH_PARITY     = 4'd6;
  localparam logic [3:0] PH_PARITY_SUB = 4'd7;
  localparam logic [3:0] PH_FLAG_CLOSE = 4'd8;
  localparam logic [3:0] PH_ACK        = 4'd9;

  logic       active_q, active_d;
  logic [3:0] phase_q, phase_d;
  logic [3:0] start_ph, cur_ph, next_ph;
  logic [7:0] byte_c;
  logic       done_c, emit;
  logic       pay_is_flag, pay_stuff, par_is_flag, par_stuff;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q, kind_q;
  logic [1:0] status_q;

  assign pay_is_flag = (head_i.pbyte == cfg_i.flag);
  assign pay_stuff   = pay_is_flag || (head_i.pbyte == cfg_i.escape);
  assign par_is_flag = (head_i.parity == cfg_i.flag);
  assign par_stuff   = par_is_flag || (head_i.parity == cfg_i.escape);

  assign start_ph = head_i.is_ack ? PH_ACK : (head_i.first ? PH_FLAG_OPEN : PH_PAYLOAD);
  assign cur_ph   = active_q ? phase_q : start_ph;

  // Select the byte of the current phase and the phase after it
  always_comb begin
    byte_c  = 8'd0;
    next_ph = cur_ph;
    done_c  = 1'b0;
    case (cur_ph)
      PH_FLAG_OPEN: begin
        byte_c  = cfg_i.flag;
        next_ph = PH_ADDRESS;
      end
      PH_ADDRESS: begin
        byte_c  = cfg_i.address;
        next_ph = PH_CTRL;
      end
      PH_CTRL: begin
        byte_c  = head_i.ctrl;
        next_ph = PH_HDR_PARITY;
      end
      PH_HDR_PARITY: begin
        byte_c  = cfg_i.address ^ head_i.ctrl;
        next_ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        byte_c  = pay_stuff ? cfg_i.escape : head_i.pbyte;
        next_ph = pay_stuff ? PH_PAYLOAD_SUB : PH_PARITY;
        done_c  = !pay_stuff && !head_i.last;
      end
      PH_PAYLOAD_SUB: begin
        byte_c  = pay_is_flag ? cfg_i.flag_subst : cfg_i.escape_subst;
        next_ph = PH_PARITY;
        done_c  = !head_i.last;
      end
      PH_PARITY: begin
        byte_c  = par_stuff ? cfg_i.escape : head_i.parity;
        next_ph = par_stuff ? PH_PARITY_SUB : PH_FLAG_CLOSE;
      end
      PH_PARITY_SUB: begin
        byte_c  = par_is_flag ? cfg_i.flag_subst : cfg_i.escape_subst;
        next_ph = PH_FLAG_CLOSE;
      end
      PH_FLAG_CLOSE: begin
        byte_c = cfg_i.flag;
        done_c = 1'b1;
      end
      PH_ACK: begin
        byte_c = 8'd0;
        done_c = 1'b1;
      end
      default: begin
        done_c = 1'b1;
      end
    endcase
  end

  // Emit one byte whenever a descriptor waits and the output register is free or drains
  assign emit     = head_valid_i && (!valid_q || out_o.ready);
  assign pop_o    = emit && done_c;
  assign active_d = emit ? !done_c : active_q;
  assign phase_d  = emit ? next_ph : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= PH_FLAG_OPEN;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      phase_q  <= phase_d;
      if (emit) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the sink takes it
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q   <= byte_c;
      last_q   <= done_c;
      kind_q   <= head_i.is_ack ? KIND_ACK : KIND_FRAME;
      status_q <= head_i.is_ack ? head_i.status : ACK_ACCEPTED;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.out_last   = last_q;
  assign out_o.out_kind   = kind_q;
  assign out_o.ack_status = status_q;

endmodule

@@ rtl/stuffed_frame_transmitter.sv @@
// Stop-and-wait frame builder with byte stuffing. Each payload transaction on
// in_i is classified at once and queued; the output sequencer then sends one
// line byte per cycle on out_o unless out_o stalls: one byte for a plain
// payload byte, two for a stuffed one, and with frame open and close added a
// single input may cause up to nine bytes. A reply transaction yields one
// status result. Input is taken in every cycle while the descriptor queue
// (QueueDepth entries) has room, so the sustained rate is set by the output
// sequencer at one result per cycle, two results per stuffed payload byte.
// Configuration writes are only to be made while the block is idle.
module stuffed_frame_transmitter #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  sft_in_if.sink     in_i,
  sft_out_if.source  out_o
);
  import sft_pkg::*;

  sft_cfg_t  cfg_q;
  sft_desc_t push_desc, head_desc;
  logic      push, full, pop, head_valid;

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag         <= FLAG_RST;
      cfg_q.escape       <= ESCAPE_RST;
      cfg_q.flag_subst   <= FLAG_SUBST_RST;
      cfg_q.escape_subst <= ESCAPE_SUBST_RST;
      cfg_q.address      <= ADDRESS_RST;
      cfg_q.ctrl_seq0    <= CTRL_SEQ0_RST;
      cfg_q.ctrl_seq1    <= CTRL_SEQ1_RST;
      cfg_q.try_limit    <= TRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FLAG:         cfg_q.flag         <= cfg_wdata_i;
        REG_ESCAPE:       cfg_q.escape       <= cfg_wdata_i;
        REG_FLAG_SUBST:   cfg_q.flag_subst   <= cfg_wdata_i;
        REG_ESCAPE_SUBST: cfg_q.escape_subst <= cfg_wdata_i;
        REG_ADDRESS:      cfg_q.address      <= cfg_wdata_i;
        REG_CTRL_SEQ0:    cfg_q.ctrl_seq0    <= cfg_wdata_i;
        REG_CTRL_SEQ1:    cfg_q.ctrl_seq1    <= cfg_wdata_i;
        REG_TRY_LIMIT:    cfg_q.try_limit    <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  sft_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .desc_o (push_desc)
  );

  sft_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (push_desc),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_desc)
  );

  sft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head_desc),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

@@ rtl/sft_checker.sv @@
module sft_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i,
  input logic       out_kind_i,
  input logic [1:0] ack_status_i
);
  import sft_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A status result is always the only result of its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_ACK |-> out_last_i && out_byte_i == 8'd0)
    else $error("status result malformed");

  // Frame bytes carry no status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_FRAME |-> ack_status_i == ACK_ACCEPTED)
    else $error("frame byte carries status");

  // No status result directly follows a taken frame byte that is not last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_kind_i == KIND_FRAME && !out_last_i
    |=> !(out_valid_i && out_kind_i == KIND_ACK))
    else $error("status result inside a frame transaction");

endmodule

bind stuffed_frame_transmitter sft_checker u_sft_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .out_last_i   (out_o.out_last),
  .out_kind_i   (out_o.out_kind),
  .ack_status_i (out_o.ack_status)
);
